// ===== rtl/lsa_pkg.sv =====
// Shared types and constants for the latency statistics accumulator.
`timescale 1ns / 1ps

package lsa_pkg;

   localparam int LOSS_BITS  = 14;
   localparam int LOSS_SCALE = 10000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_LOSS_GO,
      ST_LOSS_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_JIT_GO,
      ST_JIT_WAIT,
      ST_NQ_GO,
      ST_NQ_WAIT,
      ST_SS_GO,
      ST_SS_WAIT,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_PUBLISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_LOSS,
      DIV_AVG,
      DIV_JIT,
      DIV_VAR
   } div_op_type;

   typedef enum logic {
      MUL_NQ,
      MUL_SS
   } mul_op_type;

   typedef struct packed {
      logic       take;
      logic       square;
      logic       accum;
      logic       div_start;
      div_op_type div_op;
      logic       mul_start;
      mul_op_type mul_op;
      logic       sqrt_start;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_busy;
      logic mul_busy;
      logic sqrt_busy;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/latency_statistics_accumulator.sv =====
// Top level of the latency statistics accumulator.
//
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_rtt_us, req_reply_ok, req_last_record
// rsp       out        rsp_valid / rsp_ready   rsp_received .. rsp_count_overflow
// csr       in         csr_write_enable        csr_write_data (expected total)
//
// A request without the last marker goes through the square and accumulate steps before ready.
// A closing request then runs the loss, average and jitter divisions, two multiplications, the
// variance division and the square root in turn; four passes of the bit-serial divider set most
// of the time taken.
// Reset is synchronous and clears all running statistics and the expected total.
// A waiting result does not block the next request; a second result stalls in
// the controller until the first is taken.
`timescale 1ns / 1ps

module latency_statistics_accumulator #(
   parameter int MAX_SAMPLES = 1024,
   parameter int RTT_BITS    = 26
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [RTT_BITS-1:0]                req_rtt_us,
   input  logic                               req_reply_ok,
   input  logic                               req_last_record,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]   rsp_received,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]   rsp_sent,
   output logic [lsa_pkg::LOSS_BITS-1:0]      rsp_loss_hundredths,
   output logic [RTT_BITS-1:0]                rsp_min_rtt,
   output logic [RTT_BITS-1:0]                rsp_max_rtt,
   output logic [RTT_BITS-1:0]                rsp_avg_rtt,
   output logic [RTT_BITS-1:0]                rsp_stddev_rtt,
   output logic [RTT_BITS-1:0]                rsp_jitter_rtt,
   output logic                               rsp_has_samples,
   output logic                               rsp_count_overflow,
   input  logic                               csr_write_enable,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]   csr_write_data
);
   import lsa_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsa_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .RTT_BITS    (RTT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_rtt_us          (req_rtt_us),
      .req_reply_ok        (req_reply_ok),
      .req_last_record     (req_last_record),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_received        (rsp_received),
      .rsp_sent            (rsp_sent),
      .rsp_loss_hundredths (rsp_loss_hundredths),
      .rsp_min_rtt         (rsp_min_rtt),
      .rsp_max_rtt         (rsp_max_rtt),
      .rsp_avg_rtt         (rsp_avg_rtt),
      .rsp_stddev_rtt      (rsp_stddev_rtt),
      .rsp_jitter_rtt      (rsp_jitter_rtt),
      .rsp_has_samples     (rsp_has_samples),
      .rsp_count_overflow  (rsp_count_overflow)
   );

   a_received_le_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_received <= rsp_sent)
      else $error("received count exceeds sent count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_rtt <= rsp_max_rtt)
      else $error("minimum above maximum");

   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_loss_hundredths <= LOSS_BITS'(LOSS_SCALE))
      else $error("loss above one hundred percent");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in progress");

endmodule

// ===== rtl/lsa_datapath.sv =====
// Datapath: running sums, serial divider, serial multiplier, serial root, result register.
`timescale 1ns / 1ps

module lsa_datapath #(
   parameter int MAX_SAMPLES = 1024,
   parameter int RTT_BITS    = 26
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lsa_pkg::cmd_type                   cmd,
   output lsa_pkg::status_type                status,
   input  logic                               csr_write_enable,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]   csr_write_data,
   input  logic [RTT_BITS-1:0]                req_rtt_us,
   input  logic                               req_reply_ok,
   input  logic                               req_last_record,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]   rsp_received,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]   rsp_sent,
   output logic [lsa_pkg::LOSS_BITS-1:0]      rsp_loss_hundredths,
   output logic [RTT_BITS-1:0]                rsp_min_rtt,
   output logic [RTT_BITS-1:0]                rsp_max_rtt,
   output logic [RTT_BITS-1:0]                rsp_avg_rtt,
   output logic [RTT_BITS-1:0]                rsp_stddev_rtt,
   output logic [RTT_BITS-1:0]                rsp_jitter_rtt,
   output logic                               rsp_has_samples,
   output logic                               rsp_count_overflow
);
   import lsa_pkg::*;

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SW  = RTT_BITS + CW;
   localparam int QW  = 2 * RTT_BITS + CW;
   localparam int DW  = 2 * SW;
   localparam int DVW = 2 * CW;
   localparam int VW  = 2 * RTT_BITS;
   localparam int PW  = CW + LOSS_BITS;
   localparam int DCW = $clog2(DW + 1);
   localparam int RCW = $clog2(RTT_BITS + 1);

   // configuration
   logic [CW-1:0]       expected_ff;

   // request capture
   logic [RTT_BITS-1:0] rtt_ff;
   logic                ok_ff, last_ff;
   logic [VW-1:0]       square_ff;

   // running state
   logic [CW-1:0]       ok_count_ff, record_count_ff;
   logic [RTT_BITS-1:0] least_ff, greatest_ff, previous_ff;
   logic [SW-1:0]       sum_ff, step_sum_ff;
   logic [QW-1:0]       square_sum_ff;
   logic                overflow_ff;

   // intermediate results
   logic [LOSS_BITS-1:0] loss_ff;
   logic [RTT_BITS-1:0]  avg_ff, jit_ff;
   logic [VW-1:0]        var_ff;
   logic [DW-1:0]        nq_ff, ss_ff;

   // divider
   logic             div_busy_ff;
   div_op_type       div_op_ff;
   logic [DW-1:0]    div_quot_ff;
   logic [DVW-1:0]   div_rem_ff, div_den_ff;
   logic [DCW-1:0]   div_count_ff;
   logic [DVW:0]     div_rem_sh;
   logic             div_ge;
   logic [DW-1:0]    div_quot_in;
   logic [DW-1:0]    div_num_sel;
   logic [DVW-1:0]   div_den_sel;

   // multiplier
   logic             mul_busy_ff;
   mul_op_type       mul_op_ff;
   logic [DW-1:0]    mul_cand_ff;
   logic [SW-1:0]    mul_plier_ff;

   // square root
   logic                sqrt_busy_ff;
   logic [VW-1:0]       sqrt_x_ff;
   logic [RTT_BITS:0]   sqrt_rem_ff;
   logic [RTT_BITS-1:0] sqrt_root_ff;
   logic [RCW-1:0]      sqrt_count_ff;
   logic [RTT_BITS+2:0] sqrt_rem_sh, sqrt_trial;
   logic                sqrt_ge;

   // output register
   logic                rsp_valid_ff;

   logic [CW-1:0]       denom;
   logic                loss_live;
   logic [PW-1:0]       loss_num;
   logic [RTT_BITS-1:0] step_abs;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_write_enable) begin
         expected_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rtt_ff  <= req_rtt_us;
         ok_ff   <= req_reply_ok;
         last_ff <= req_last_record;
      end
      if (cmd.square) begin
         square_ff <= VW'(rtt_ff) * VW'(rtt_ff);
      end
   end

   assign step_abs = (rtt_ff > previous_ff) ? rtt_ff - previous_ff : previous_ff - rtt_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.publish) begin
         ok_count_ff     <= '0;
         record_count_ff <= '0;
         least_ff        <= '1;
         greatest_ff     <= '0;
         sum_ff          <= '0;
         step_sum_ff     <= '0;
         square_sum_ff   <= '0;
         previous_ff     <= '0;
         overflow_ff     <= 1'b0;
      end else if (cmd.accum) begin
         if (record_count_ff >= CW'(MAX_SAMPLES)) begin
            overflow_ff <= 1'b1;
         end else begin
            record_count_ff <= record_count_ff + 1'b1;
            if (ok_ff) begin
               if (ok_count_ff != '0) begin
                  step_sum_ff <= step_sum_ff + SW'(step_abs);
               end
               ok_count_ff   <= ok_count_ff + 1'b1;
               sum_ff        <= sum_ff + SW'(rtt_ff);
               square_sum_ff <= square_sum_ff + QW'(square_ff);
               previous_ff   <= rtt_ff;
               if (rtt_ff < least_ff) begin
                  least_ff <= rtt_ff;
               end
               if (rtt_ff > greatest_ff) begin
                  greatest_ff <= rtt_ff;
               end
            end
         end
      end
   end

   // divider operand selection; zero divisors are steered to one and the
   // result is masked at publish (for loss the numerator is zeroed instead)
   assign denom     = (expected_ff != '0) ? expected_ff : record_count_ff;
   assign loss_live = (denom != '0) && (ok_count_ff < denom);
   assign loss_num  = PW'(LOSS_SCALE) * PW'(denom - ok_count_ff);

   always_comb begin
      div_num_sel = '0;
      div_den_sel = DVW'(1);
      case (cmd.div_op)
         DIV_LOSS: begin
            if (loss_live) begin
               div_num_sel = DW'(loss_num);
               div_den_sel = DVW'(denom);
            end
         end
         DIV_AVG: begin
            div_num_sel = DW'(sum_ff);
            if (ok_count_ff != '0) div_den_sel = DVW'(ok_count_ff);
         end
         DIV_JIT: begin
            div_num_sel = DW'(step_sum_ff);
            if (ok_count_ff > CW'(1)) div_den_sel = DVW'(ok_count_ff - 1'b1);
         end
         default: begin
            div_num_sel = nq_ff - ss_ff;
            if (ok_count_ff != '0) div_den_sel = DVW'(ok_count_ff) * DVW'(ok_count_ff);
         end
      endcase
   end

   assign div_rem_sh  = {div_rem_ff, div_quot_ff[DW-1]};
   assign div_ge      = div_rem_sh >= {1'b0, div_den_ff};
   assign div_quot_in = {div_quot_ff[DW-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff  <= 1'b1;
         div_op_ff    <= cmd.div_op;
         div_quot_ff  <= div_num_sel;
         div_den_ff   <= div_den_sel;
         div_rem_ff   <= '0;
         div_count_ff <= DCW'(DW);
      end else if (div_busy_ff) begin
         div_quot_ff  <= div_quot_in;
         div_rem_ff   <= div_ge ? DVW'(div_rem_sh - {1'b0, div_den_ff}) : DVW'(div_rem_sh);
         div_count_ff <= div_count_ff - 1'b1;
         if (div_count_ff == DCW'(1)) begin
            div_busy_ff <= 1'b0;
            case (div_op_ff)
               DIV_LOSS: loss_ff <= div_quot_in[LOSS_BITS-1:0];
               DIV_AVG:  avg_ff  <= div_quot_in[RTT_BITS-1:0];
               DIV_JIT:  jit_ff  <= div_quot_in[RTT_BITS-1:0];
               default:  var_ff  <= div_quot_in[VW-1:0];
            endcase
         end
      end
   end

   // shift-add multiplier, accumulating straight into the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mul_busy_ff <= 1'b1;
         mul_op_ff   <= cmd.mul_op;
         if (cmd.mul_op == MUL_NQ) begin
            mul_cand_ff  <= DW'(square_sum_ff);
            mul_plier_ff <= SW'(ok_count_ff);
            nq_ff        <= '0;
         end else begin
            mul_cand_ff  <= DW'(sum_ff);
            mul_plier_ff <= sum_ff;
            ss_ff        <= '0;
         end
      end else if (mul_busy_ff) begin
         if (mul_plier_ff == '0) begin
            mul_busy_ff <= 1'b0;
         end else begin
            if (mul_plier_ff[0]) begin
               if (mul_op_ff == MUL_NQ) nq_ff <= nq_ff + mul_cand_ff;
               else                     ss_ff <= ss_ff + mul_cand_ff;
            end
            mul_cand_ff  <= {mul_cand_ff[DW-2:0], 1'b0};
            mul_plier_ff <= mul_plier_ff >> 1;
         end
      end
   end

   // digit-by-digit root, two radicand bits per cycle
   assign sqrt_rem_sh = {sqrt_rem_ff, sqrt_x_ff[VW-1 -: 2]};
   assign sqrt_trial  = (RTT_BITS+3)'({sqrt_root_ff, 2'b01});
   assign sqrt_ge     = sqrt_rem_sh >= sqrt_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_busy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sqrt_busy_ff  <= 1'b1;
         sqrt_x_ff     <= var_ff;
         sqrt_rem_ff   <= '0;
         sqrt_root_ff  <= '0;
         sqrt_count_ff <= RCW'(RTT_BITS);
      end else if (sqrt_busy_ff) begin
         sqrt_x_ff     <= {sqrt_x_ff[VW-3:0], 2'b00};
         sqrt_rem_ff   <= sqrt_ge ? (RTT_BITS+1)'(sqrt_rem_sh - sqrt_trial)
                                  : (RTT_BITS+1)'(sqrt_rem_sh);
         sqrt_root_ff  <= {sqrt_root_ff[RTT_BITS-2:0], sqrt_ge};
         sqrt_count_ff <= sqrt_count_ff - 1'b1;
         if (sqrt_count_ff == RCW'(1)) begin
            sqrt_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_received        <= ok_count_ff;
         rsp_sent            <= record_count_ff;
         rsp_loss_hundredths <= loss_ff;
         rsp_has_samples     <= ok_count_ff != '0;
         rsp_count_overflow  <= overflow_ff;
         rsp_max_rtt         <= greatest_ff;
         if (ok_count_ff != '0) begin
            rsp_min_rtt    <= least_ff;
            rsp_avg_rtt    <= avg_ff;
            rsp_stddev_rtt <= sqrt_root_ff;
         end else begin
            rsp_min_rtt    <= '0;
            rsp_avg_rtt    <= '0;
            rsp_stddev_rtt <= '0;
         end
         rsp_jitter_rtt <= (ok_count_ff > CW'(1)) ? jit_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.last      = last_ff;
   assign status.div_busy  = div_busy_ff;
   assign status.mul_busy  = mul_busy_ff;
   assign status.sqrt_busy = sqrt_busy_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

// ===== rtl/lsa_ctrl.sv =====
// Controller: sequences accumulation and the closing computations.
`timescale 1ns / 1ps

module lsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lsa_pkg::status_type status,
   output lsa_pkg::cmd_type    cmd
);
   import lsa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_ACCUM;
         ST_ACCUM:     state_in = status.last ? ST_LOSS_GO : ST_IDLE;
         ST_LOSS_GO:   state_in = ST_LOSS_WAIT;
         ST_LOSS_WAIT: if (!status.div_busy) state_in = ST_AVG_GO;
         ST_AVG_GO:    state_in = ST_AVG_WAIT;
         ST_AVG_WAIT:  if (!status.div_busy) state_in = ST_JIT_GO;
         ST_JIT_GO:    state_in = ST_JIT_WAIT;
         ST_JIT_WAIT:  if (!status.div_busy) state_in = ST_NQ_GO;
         ST_NQ_GO:     state_in = ST_NQ_WAIT;
         ST_NQ_WAIT:   if (!status.mul_busy) state_in = ST_SS_GO;
         ST_SS_GO:     state_in = ST_SS_WAIT;
         ST_SS_WAIT:   if (!status.mul_busy) state_in = ST_VAR_GO;
         ST_VAR_GO:    state_in = ST_VAR_WAIT;
         ST_VAR_WAIT:  if (!status.div_busy) state_in = ST_ROOT_GO;
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (!status.sqrt_busy) state_in = ST_PUBLISH;
         ST_PUBLISH:   if (!status.rsp_busy) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.div_op = DIV_LOSS;
      cmd.mul_op = MUL_NQ;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_SQUARE:  cmd.square = 1'b1;
         ST_ACCUM:   cmd.accum  = 1'b1;
         ST_LOSS_GO: cmd.div_start = 1'b1;
         ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_AVG;
         end
         ST_JIT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_JIT;
         end
         ST_NQ_GO:   cmd.mul_start = 1'b1;
         ST_SS_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_SS;
         end
         ST_VAR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_VAR;
         end
         ST_ROOT_GO: cmd.sqrt_start = 1'b1;
         // hold until the result register frees up
         ST_PUBLISH: cmd.publish = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

// ===== dv/lsa_checker.sv =====
// Checker for the latency statistics accumulator: predicts each closing result and compares it.
`timescale 1ns / 1ps

module lsa_checker #(
   parameter int MAX_SAMPLES = 1024,
   parameter int RTT_BITS    = 26,
   parameter int CW          = $clog2(MAX_SAMPLES+1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [RTT_BITS-1:0]          req_rtt_us,
   input  logic                         req_reply_ok,
   input  logic                         req_last_record,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [CW-1:0]                rsp_received,
   input  logic [CW-1:0]                rsp_sent,
   input  logic [lsa_pkg::LOSS_BITS-1:0] rsp_loss_hundredths,
   input  logic [RTT_BITS-1:0]          rsp_min_rtt,
   input  logic [RTT_BITS-1:0]          rsp_max_rtt,
   input  logic [RTT_BITS-1:0]          rsp_avg_rtt,
   input  logic [RTT_BITS-1:0]          rsp_stddev_rtt,
   input  logic [RTT_BITS-1:0]          rsp_jitter_rtt,
   input  logic                         rsp_has_samples,
   input  logic                         rsp_count_overflow,
   input  logic                         csr_write_enable,
   input  logic [CW-1:0]                csr_write_data,
   output int                           fail_count,
   output int                           pending_count
);
   import lsa_pkg::*;

   typedef struct packed {
      logic [CW-1:0]                received;
      logic [CW-1:0]                sent;
      logic [LOSS_BITS-1:0]         loss;
      logic [RTT_BITS-1:0]          min_rtt;
      logic [RTT_BITS-1:0]          max_rtt;
      logic [RTT_BITS-1:0]          avg_rtt;
      logic [RTT_BITS-1:0]          stddev_rtt;
      logic [RTT_BITS-1:0]          jitter_rtt;
      logic                         has_samples;
      logic                         overflow;
   } summary_type;

   summary_type summary_q[$];

   logic [CW-1:0] exp_total;
   longint unsigned ok_n, rec_n, least, most, sum, sq_sum, diff_sum, prev_rtt;
   bit ovf;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // floor(sq/n - (s/n)^2) in integers, computed exactly with wide arithmetic
   function automatic longint unsigned pop_variance(longint unsigned n, longint unsigned s,
                                                    longint unsigned sq);
      logic [127:0] num, ssq;
      ssq = 128'(s) * 128'(s);
      num = 128'(sq) * 128'(n);
      if (num <= ssq) return 0;
      return 64'((num - ssq) / (128'(n) * 128'(n)));
   endfunction

   task automatic clear_stats();
      ok_n = 0; rec_n = 0; least = (64'd1 << RTT_BITS) - 1; most = 0;
      sum = 0; sq_sum = 0; diff_sum = 0; prev_rtt = 0; ovf = 0;
   endtask

   task automatic take_record(longint unsigned rtt, bit ok, bit last);
      summary_type s;
      longint unsigned den;
      if (rec_n >= MAX_SAMPLES) begin
         ovf = 1;
      end else begin
         rec_n++;
         if (ok) begin
            if (ok_n > 0) diff_sum += (rtt > prev_rtt) ? rtt - prev_rtt : prev_rtt - rtt;
            ok_n++;
            if (rtt < least) least = rtt;
            if (rtt > most) most = rtt;
            sum += rtt;
            sq_sum += rtt * rtt;
            prev_rtt = rtt;
         end
      end
      if (!last) return;
      s = '0;
      den = (exp_total != 0) ? exp_total : rec_n;
      if (den != 0 && ok_n < den) s.loss = LOSS_BITS'((10000 * (den - ok_n)) / den);
      if (ok_n > 0) begin
         s.min_rtt = RTT_BITS'(least);
         s.max_rtt = RTT_BITS'(most);
         s.avg_rtt = RTT_BITS'(sum / ok_n);
         s.stddev_rtt = RTT_BITS'(int_sqrt(pop_variance(ok_n, sum, sq_sum)));
         if (ok_n > 1) s.jitter_rtt = RTT_BITS'(diff_sum / (ok_n - 1));
      end
      s.received = CW'(ok_n);
      s.sent = CW'(rec_n);
      s.has_samples = ok_n > 0;
      s.overflow = ovf;
      summary_q.insert(summary_q.size(), s);
      clear_stats();
   endtask

   always @(posedge clock) begin
      summary_type e;
      if (reset) begin
         exp_total <= '0;
         clear_stats();
         summary_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_write_enable) exp_total <= csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               $error("result with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = summary_q.pop_front();
               if (rsp_received !== e.received || rsp_sent !== e.sent ||
                   rsp_loss_hundredths !== e.loss || rsp_min_rtt !== e.min_rtt ||
                   rsp_max_rtt !== e.max_rtt || rsp_avg_rtt !== e.avg_rtt ||
                   rsp_stddev_rtt !== e.stddev_rtt || rsp_jitter_rtt !== e.jitter_rtt ||
                   rsp_has_samples !== e.has_samples ||
                   rsp_count_overflow !== e.overflow)
                  fail_count <= fail_count + 1;
               if (rsp_received !== e.received)
                  $error("received: expected %0d got %0d", e.received, rsp_received);
               if (rsp_sent !== e.sent)
                  $error("sent: expected %0d got %0d", e.sent, rsp_sent);
               if (rsp_loss_hundredths !== e.loss)
                  $error("loss_hundredths: expected %0d got %0d", e.loss, rsp_loss_hundredths);
               if (rsp_min_rtt !== e.min_rtt)
                  $error("min_rtt: expected %0d got %0d", e.min_rtt, rsp_min_rtt);
               if (rsp_max_rtt !== e.max_rtt)
                  $error("max_rtt: expected %0d got %0d", e.max_rtt, rsp_max_rtt);
               if (rsp_avg_rtt !== e.avg_rtt)
                  $error("avg_rtt: expected %0d got %0d", e.avg_rtt, rsp_avg_rtt);
               if (rsp_stddev_rtt !== e.stddev_rtt)
                  $error("stddev_rtt: expected %0d got %0d", e.stddev_rtt, rsp_stddev_rtt);
               if (rsp_jitter_rtt !== e.jitter_rtt)
                  $error("jitter_rtt: expected %0d got %0d", e.jitter_rtt, rsp_jitter_rtt);
               if (rsp_has_samples !== e.has_samples)
                  $error("has_samples: expected %0d got %0d", e.has_samples, rsp_has_samples);
               if (rsp_count_overflow !== e.overflow)
                  $error("count_overflow: expected %0d got %0d", e.overflow,
                         rsp_count_overflow);
            end
         end
         // predict after the compare so a same-edge result pairs with the older entry
         if (req_valid && req_ready) take_record(req_rtt_us, req_reply_ok, req_last_record);
         pending_count <= summary_q.size();
      end
   end

endmodule

// ===== dv/tb_latency_statistics_accumulator.sv =====
// Testbench top for the latency statistics accumulator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_latency_statistics_accumulator;

   localparam int MAX_SAMPLES = 1024;
   localparam int RTT_BITS    = 26;
   localparam int CW          = $clog2(MAX_SAMPLES+1);
   localparam int DRAIN_WAIT  = 600;
   localparam int STALL_LIMIT = 20000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_reply_ok = 0, req_last_record = 0;
   logic [RTT_BITS-1:0] req_rtt_us = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [CW-1:0] rsp_received, rsp_sent;
   logic [lsa_pkg::LOSS_BITS-1:0] rsp_loss_hundredths;
   logic [RTT_BITS-1:0] rsp_min_rtt, rsp_max_rtt, rsp_avg_rtt, rsp_stddev_rtt, rsp_jitter_rtt;
   logic rsp_has_samples, rsp_count_overflow;
   logic csr_write_enable = 0;
   logic [CW-1:0] csr_write_data = '0;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit calm = 0, hold_rsp = 0;

   always #5 clock = ~clock;

   latency_statistics_accumulator #(.MAX_SAMPLES(MAX_SAMPLES), .RTT_BITS(RTT_BITS)) u_top (.*);

   lsa_checker #(.MAX_SAMPLES(MAX_SAMPLES), .RTT_BITS(RTT_BITS)) u_checker (.*);

   // response side: random stall bursts, plus one long hold-off
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= !reset;
      end else if (hold_rsp) begin
         rsp_ready <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
         rsp_ready <= 1;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("[latency_statistics_accumulator] ERROR");
         $finish;
      end
   end

   // leave valid high on return; callers drop it before waiting
   task automatic send_request(logic [RTT_BITS-1:0] rtt, bit ok, bit last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1;
      req_rtt_us <= rtt;
      req_reply_ok <= ok;
      req_last_record <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_total(int value);
      req_valid <= 0;
      // hold until all results are out and the closing computation is done
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= CW'(value);
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [RTT_BITS-1:0] pick_rtt();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return RTT_BITS'($urandom_range(0, 1000));
         default: return RTT_BITS'($urandom());
      endcase
   endfunction

   task automatic send_set(int len, int ok_pct);
      for (int i = 0; i < len; i++)
         send_request(pick_rtt(), $urandom_range(0, 99) < ok_pct, i == len - 1);
   endtask

   initial begin
      int totals[6];
      totals = '{0, 1024, 1, 5, 2047, 37};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, lone failure, single sample, zero denominator impossible case
      send_request('1, 1, 1);
      send_request('0, 0, 1);
      send_request('0, 1, 0);
      send_request('1, 1, 0);
      send_request(26'h155_5555, 0, 0);
      send_request(26'h2AA_AAAA, 1, 1);
      write_total(3);
      send_set(8, 100);
      send_set(5, 0);
      for (int t = 0; t < 6; t++) begin
         write_total(totals[t]);
         if (t == 2) begin
            // long hold-off on the response side while requests keep flowing
            hold_rsp = 1;
            fork
               begin
                  repeat (3000) @(posedge clock);
                  hold_rsp = 0;
               end
               begin
                  send_set(2, 50); send_set(3, 90); send_set(1, 100); send_set(2, 100);
               end
            join
         end
         for (int k = 0; k < 12; k++) begin
            int len;
            len = $urandom_range(1, 9);
            if (t == 5) calm = 1;
            send_set(len, $urandom_range(0, 3) == 0 ? $urandom_range(0, 100) : 90);
         end
      end
      // one last closing set of four records, all replies good
      send_set(4, 100);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("[latency_statistics_accumulator] OK");
      else
         $display("[latency_statistics_accumulator] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lsa_pkg.sv
rtl/lsa_datapath.sv
rtl/lsa_ctrl.sv
rtl/latency_statistics_accumulator.sv
dv/lsa_checker.sv
dv/tb_latency_statistics_accumulator.sv
